>>> rtl/iesd_pkg.sv
// Shared types and constants for the input event stream decoder.
// Holds the operation codes, stream opcodes, report kinds and reset values.
// No dependencies.
package iesd_pkg;

  // Operation carried by each input beat.
  typedef logic [1:0] op_t;
  localparam op_t OP_BYTE = 2'd0;
  localparam op_t OP_TICK = 2'd1;
  localparam op_t OP_POLL = 2'd2;

  // Stream opcodes, as the low three bits of bytes 0xE1 to 0xE7.
  typedef logic [2:0] opcode_t;
  localparam opcode_t OPC_KEY      = 3'd1;
  localparam opcode_t OPC_TOUCH    = 3'd2;
  localparam opcode_t OPC_TOUCH_UP = 3'd3;
  localparam opcode_t OPC_HOME     = 3'd4;
  localparam opcode_t OPC_GPS      = 3'd5;
  localparam opcode_t OPC_SENSOR   = 3'd6;
  localparam opcode_t OPC_BATTERY  = 3'd7;

  localparam logic [7:0] OPC_BYTE_FIRST = 8'hE1;
  localparam logic [7:0] OPC_BYTE_LAST  = 8'hE7;

  // Key numbers in a key event.
  localparam logic [7:0] KEY_BOOT = 8'd1;
  localparam logic [7:0] KEY_SIDE = 8'd2;

  // Report kinds.
  typedef logic [1:0] kind_t;
  localparam kind_t EV_NONE    = 2'd0;
  localparam kind_t EV_GPS     = 2'd1;
  localparam kind_t EV_SENSOR  = 2'd2;
  localparam kind_t EV_BATTERY = 2'd3;

  // Sensor values that mean "not measured".
  localparam logic [7:0]  ABSENT_U8  = 8'hFF;
  localparam logic [15:0] ABSENT_U16 = 16'hFFFF;

  // Reset value of the minimum key hold.
  localparam logic [15:0] MIN_HOLD_RESET = 16'd250;

endpackage

>>> rtl/input_event_stream_decoder.sv
// Input event stream decoder: parses opcode-led event bytes, keeps key,
// touch and home state, and reports one result beat per input beat.
// Depends on iesd_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one beat per operation:
//   a stream byte, a one millisecond tick, or a poll that reports and then
//   clears the pending home press. Every accepted input beat yields exactly
//   one result beat on the out_ channel, carrying the current key, touch
//   and home status together with any GPS byte, sensor or battery report
//   that the beat completed.
//   Each result is registered and valid after the edge that accepts its
//   beat. Throughput is one beat per cycle unless the receiver stalls, set
//   by the single result register; parser and key timers are combinational.
//   If the receiver stalls, the result register holds its beat and the
//   input stays ready only when that beat is taken in the same cycle.
//   The cfg_ channel writes the minimum key hold in milliseconds; it is
//   always ready and should be written only while no beat is in flight.
//   Reset (rst_n low, synchronous) returns the parser to idle, clears all
//   key, touch and home state and the time base, sets the minimum hold to
//   250 ms, and empties the result register.
module input_event_stream_decoder #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  iesd_pkg::op_t        in_op,
  input  logic [7:0]           in_data_byte,

  output logic                 out_valid,
  input  logic                 out_ready,
  output iesd_pkg::kind_t      out_event_kind,
  output logic [7:0]           out_value_a,
  output logic [15:0]          out_value_b,
  output logic [7:0]           out_value_c,
  output logic [2:0]           out_present_mask,
  output logic                 out_boot_down,
  output logic                 out_side_down,
  output logic                 out_touch_down,
  output logic signed [15:0]   out_touch_x,
  output logic signed [15:0]   out_touch_y,
  output logic                 out_home_press,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_min_hold_ms
);

  import iesd_pkg::*;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PAYLOAD,
    PH_GPSLEN,
    PH_GPSDATA
  } phase_t;

  // Handshake.
  logic in_accept;

  // Configuration.
  logic [15:0] min_hold_r;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  opcode_t     opc_r, opc_nxt;
  logic [1:0]  bs_r, bs_nxt;          // payload bytes already taken
  logic [31:0] shift_r, shift_nxt;    // payload bytes, little endian
  logic [7:0]  gps_rem_r, gps_rem_nxt;
  logic [31:0] word;                  // payload including the current byte
  logic [1:0]  last_idx;
  logic        byte_is_opc;

  // Touch and home state.
  logic               touch_dn_r, touch_dn_nxt;
  logic signed [15:0] tx_r, tx_nxt;
  logic signed [15:0] ty_r, ty_nxt;
  logic               home_r, home_nxt;
  logic               home_set;
  logic               home_rep;

  // Key state. Index 0 is the boot key, index 1 the side key.
  // held counts milliseconds since the last press; marg counts milliseconds
  // past the scheduled release time and goes non-negative when it is due.
  logic                 tick;
  logic [1:0]           key_hit;
  logic                 key_dn;
  logic [1:0]           pressed_r, pressed_nxt;
  logic [1:0]           pend_r, pend_nxt;
  logic [TIME_BITS-1:0] held_r [2];
  logic [TIME_BITS-1:0] held_nxt [2];
  logic [TIME_BITS-1:0] marg_r [2];
  logic [TIME_BITS-1:0] marg_nxt [2];
  logic [TIME_BITS:0]   hold_diff [2];
  logic [TIME_BITS:0]   min_hold_ext;

  // Result register.
  logic        out_valid_r;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  va_r, va_nxt;
  logic [15:0] vb_r, vb_nxt;
  logic [7:0]  vc_r, vc_nxt;
  logic [2:0]  mask_r, mask_nxt;
  logic        boot_r, side_r;
  logic        touch_o_r;
  logic signed [15:0] tx_o_r, ty_o_r;
  logic        home_o_r;

  // A new beat is taken whenever the result register is empty or drains
  // in this same cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign tick         = (in_op == OP_TICK);
  assign byte_is_opc  = (in_data_byte >= OPC_BYTE_FIRST) && (in_data_byte <= OPC_BYTE_LAST);
  assign min_hold_ext = (TIME_BITS + 1)'(min_hold_r);

  // Key and battery events carry two payload bytes, touch and sensor four.
  assign last_idx = ((opc_r == OPC_TOUCH) || (opc_r == OPC_SENSOR)) ? 2'd3 : 2'd1;

  // Parser, touch and report decode.
  always_comb begin
    phase_nxt    = phase_r;
    opc_nxt      = opc_r;
    bs_nxt       = bs_r;
    shift_nxt    = shift_r;
    gps_rem_nxt  = gps_rem_r;
    touch_dn_nxt = touch_dn_r;
    tx_nxt       = tx_r;
    ty_nxt       = ty_r;
    home_set     = 1'b0;
    key_hit      = 2'b00;
    key_dn       = 1'b0;
    kind_nxt     = EV_NONE;
    va_nxt       = 8'd0;
    vb_nxt       = 16'd0;
    vc_nxt       = 8'd0;
    mask_nxt     = 3'd0;

    word = shift_r;
    word[{bs_r, 3'b000} +: 8] = in_data_byte;

    if (in_op == OP_BYTE) begin
      unique case (phase_r)
        PH_IDLE: begin
          // Bytes other than a known opcode are dropped here, which is how
          // the parser regains sync after a corrupted event.
          if (byte_is_opc) begin
            opc_nxt   = in_data_byte[2:0];
            bs_nxt    = 2'd0;
            shift_nxt = 32'd0;
            unique case (in_data_byte[2:0])
              OPC_TOUCH_UP: touch_dn_nxt = 1'b0;
              OPC_HOME:     home_set     = 1'b1;
              OPC_GPS:      phase_nxt    = PH_GPSLEN;
              default:      phase_nxt    = PH_PAYLOAD;
            endcase
          end
        end
        PH_GPSLEN: begin
          gps_rem_nxt = in_data_byte;
          phase_nxt   = (in_data_byte == 8'd0) ? PH_IDLE : PH_GPSDATA;
        end
        PH_GPSDATA: begin
          kind_nxt    = EV_GPS;
          va_nxt      = in_data_byte;
          gps_rem_nxt = gps_rem_r - 8'd1;
          if (gps_rem_r == 8'd1) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_PAYLOAD: begin
          shift_nxt = word;
          bs_nxt    = bs_r + 2'd1;
          if (bs_r == last_idx) begin
            phase_nxt = PH_IDLE;
            bs_nxt    = 2'd0;
            shift_nxt = 32'd0;
            unique case (opc_r)
              OPC_KEY: begin
                key_dn = (word[15:8] != 8'd0);
                if (word[7:0] == KEY_BOOT) begin
                  key_hit[0] = 1'b1;
                end else if (word[7:0] == KEY_SIDE) begin
                  key_hit[1] = 1'b1;
                end
              end
              OPC_TOUCH: begin
                tx_nxt       = signed'(word[15:0]);
                ty_nxt       = signed'(word[31:16]);
                touch_dn_nxt = 1'b1;
              end
              OPC_SENSOR: begin
                kind_nxt = EV_SENSOR;
                if (word[7:0] != ABSENT_U8) begin
                  va_nxt      = word[7:0];
                  mask_nxt[0] = 1'b1;
                end
                if (word[23:8] != ABSENT_U16) begin
                  vb_nxt      = word[23:8];
                  mask_nxt[1] = 1'b1;
                end
                if (word[31:24] != ABSENT_U8) begin
                  vc_nxt      = word[31:24];
                  mask_nxt[2] = 1'b1;
                end
              end
              OPC_BATTERY: begin
                kind_nxt = EV_BATTERY;
                va_nxt   = word[7:0];
                vb_nxt   = {15'd0, (word[15:8] != 8'd0)};
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  // Home flag: a poll reports the flag, including a press set by this same
  // beat, and then clears it.
  assign home_rep = home_r || home_set;
  assign home_nxt = (in_op == OP_POLL) ? 1'b0 : home_rep;

  // Key hold logic. A release that comes before the minimum hold is turned
  // into a pending release; the level is resolved after this beat's update.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      held_nxt[k]    = held_r[k] + TIME_BITS'(tick);
      marg_nxt[k]    = marg_r[k] + TIME_BITS'(tick);
      pressed_nxt[k] = pressed_r[k];
      pend_nxt[k]    = pend_r[k];
      // Top bit set means the key has been held less than the minimum.
      hold_diff[k]   = {1'b0, held_r[k]} - min_hold_ext;

      if (key_hit[k]) begin
        if (key_dn) begin
          pressed_nxt[k] = 1'b1;
          held_nxt[k]    = '0;
          pend_nxt[k]    = 1'b0;
        end else if (pressed_r[k]) begin
          if (!hold_diff[k][TIME_BITS]) begin
            pressed_nxt[k] = 1'b0;
            pend_nxt[k]    = 1'b0;
          end else begin
            pend_nxt[k] = 1'b1;
            marg_nxt[k] = hold_diff[k][TIME_BITS-1:0];
          end
        end
      end

      if (pressed_nxt[k] && pend_nxt[k] && !marg_nxt[k][TIME_BITS-1]) begin
        pressed_nxt[k] = 1'b0;
        pend_nxt[k]    = 1'b0;
      end
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_hold_r  <= MIN_HOLD_RESET;
      phase_r     <= PH_IDLE;
      opc_r       <= '0;
      bs_r        <= '0;
      shift_r     <= '0;
      gps_rem_r   <= '0;
      touch_dn_r  <= 1'b0;
      tx_r        <= '0;
      ty_r        <= '0;
      home_r      <= 1'b0;
      pressed_r   <= '0;
      pend_r      <= '0;
      for (int k = 0; k < 2; k++) begin
        held_r[k] <= '0;
        marg_r[k] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_hold_r <= cfg_min_hold_ms;
      end
      if (in_accept) begin
        phase_r    <= phase_nxt;
        opc_r      <= opc_nxt;
        bs_r       <= bs_nxt;
        shift_r    <= shift_nxt;
        gps_rem_r  <= gps_rem_nxt;
        touch_dn_r <= touch_dn_nxt;
        tx_r       <= tx_nxt;
        ty_r       <= ty_nxt;
        home_r     <= home_nxt;
        pressed_r  <= pressed_nxt;
        pend_r     <= pend_nxt;
        for (int k = 0; k < 2; k++) begin
          held_r[k] <= held_nxt[k];
          marg_r[k] <= marg_nxt[k];
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r    <= kind_nxt;
      va_r      <= va_nxt;
      vb_r      <= vb_nxt;
      vc_r      <= vc_nxt;
      mask_r    <= mask_nxt;
      boot_r    <= pressed_nxt[0];
      side_r    <= pressed_nxt[1];
      touch_o_r <= touch_dn_nxt;
      tx_o_r    <= tx_nxt;
      ty_o_r    <= ty_nxt;
      home_o_r  <= home_rep;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = kind_r;
  assign out_value_a      = va_r;
  assign out_value_b      = vb_r;
  assign out_value_c      = vc_r;
  assign out_present_mask = mask_r;
  assign out_boot_down    = boot_r;
  assign out_side_down    = side_r;
  assign out_touch_down   = touch_o_r;
  assign out_touch_x      = tx_o_r;
  assign out_touch_y      = ty_o_r;
  assign out_home_press   = home_o_r;

endmodule

>>> verif/input_event_stream_decoder_tb.sv
// Self-checking testbench for input_event_stream_decoder: directed event frames,
// then random well-formed traffic, checked beat by beat against a local predictor.
// Depends on iesd_pkg and the decoder RTL; needs no other file.
`timescale 1ns / 1ps

module input_event_stream_decoder_tb;
  import iesd_pkg::*;

  // Op code 3 is unused by the block; it must report status and change nothing.
  localparam op_t OP_NONE = 2'd3;

  // Key state bytes in a key event and the key slots of the predictor.
  localparam logic [7:0] KEY_UP_BYTE   = 8'd0;
  localparam logic [7:0] KEY_DOWN_BYTE = 8'd1;
  localparam int BOOT_SLOT = 0;
  localparam int SIDE_SLOT = 1;

  // Bits of the present mask in a sensor report.
  localparam int HR_BIT      = 0;
  localparam int POWER_BIT   = 1;
  localparam int CADENCE_BIT = 2;

  // Watchdog limit on cycles without any beat, and the long receiver hold-off.
  localparam int QUIET_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PRINT_LIMIT     = 40;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_PAYLOAD,
    PARSE_GPS_LEN,
    PARSE_GPS_DATA
  } parse_state_e;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } stream_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value_a;
    logic [15:0] value_b;
    logic [7:0]  value_c;
    logic [2:0]  present;
    logic        boot;
    logic        side;
    logic        touch;
    logic [15:0] x;
    logic [15:0] y;
    logic        home;
  } status_beat_t;

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  op_t         in_op = OP_BYTE;
  logic [7:0]  in_data_byte = 8'd0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  kind_t       out_event_kind;
  logic [7:0]  out_value_a;
  logic [15:0] out_value_b;
  logic [7:0]  out_value_c;
  logic [2:0]  out_present_mask;
  logic        out_boot_down;
  logic        out_side_down;
  logic        out_touch_down;
  logic signed [15:0] out_touch_x;
  logic signed [15:0] out_touch_y;
  logic        out_home_press;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_min_hold_ms = MIN_HOLD_RESET;

  input_event_stream_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_value_a      (out_value_a),
    .out_value_b      (out_value_b),
    .out_value_c      (out_value_c),
    .out_present_mask (out_present_mask),
    .out_boot_down    (out_boot_down),
    .out_side_down    (out_side_down),
    .out_touch_down   (out_touch_down),
    .out_touch_x      (out_touch_x),
    .out_touch_y      (out_touch_y),
    .out_home_press   (out_home_press),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_min_hold_ms  (cfg_min_hold_ms)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the decoder's parser, key timers, touch and
  // home state, and its own copy of the minimum hold register.
  // ---------------------------------------------------------------------------
  logic [15:0]  hold_ms_copy = MIN_HOLD_RESET;
  parse_state_e parse_state = PARSE_IDLE;
  opcode_t      cur_opcode = '0;
  logic [2:0]   payload_count = '0;
  logic [31:0]  payload_word = '0;
  logic [7:0]   gps_left = '0;
  logic [31:0]  now_ms = '0;
  logic         key_pressed [2] = '{1'b0, 1'b0};
  logic         key_release_due [2] = '{1'b0, 1'b0};
  logic [31:0]  key_down_at [2] = '{32'd0, 32'd0};
  logic [31:0]  key_release_at [2] = '{32'd0, 32'd0};
  logic         touch_is_down = 1'b0;
  logic [15:0]  touch_x_last = '0;
  logic [15:0]  touch_y_last = '0;
  logic         home_flag = 1'b0;

  // Press restarts the hold. A release that comes too early is deferred until
  // the press has been visible for the full minimum hold.
  function automatic void update_key(input int slot, input logic down);
    logic [31:0] held;
    if (down) begin
      key_pressed[slot] = 1'b1;
      key_down_at[slot] = now_ms;
      key_release_due[slot] = 1'b0;
    end else if (key_pressed[slot]) begin
      held = now_ms - key_down_at[slot];
      if (held >= {16'd0, hold_ms_copy}) begin
        key_pressed[slot] = 1'b0;
        key_release_due[slot] = 1'b0;
      end else begin
        key_release_at[slot] = now_ms + ({16'd0, hold_ms_copy} - held);
        key_release_due[slot] = 1'b1;
      end
    end
  endfunction

  // A deferred release takes effect once the time base has reached it; the
  // comparison is modular, with the top bit of the difference as the sign.
  function automatic logic resolve_key(input int slot);
    logic [31:0] since;
    since = now_ms - key_release_at[slot];
    if (key_pressed[slot] && key_release_due[slot] && !since[31]) begin
      key_pressed[slot] = 1'b0;
      key_release_due[slot] = 1'b0;
    end
    return key_pressed[slot];
  endfunction

  // Advances the predictor by one input beat and returns the status beat that
  // the decoder must produce for it.
  function automatic status_beat_t decode_beat(input op_t op, input logic [7:0] b);
    status_beat_t r;
    logic [2:0]   need;
    logic [7:0]   p0, p1, p2, p3;
    logic [15:0]  power;
    r = '0;
    if (op == OP_BYTE) begin
      case (parse_state)
        PARSE_IDLE: begin
          // Anything outside the opcode range is dropped while idle.
          if (b >= OPC_BYTE_FIRST && b <= OPC_BYTE_LAST) begin
            cur_opcode = opcode_t'(b[2:0]);
            payload_count = '0;
            payload_word = '0;
            case (cur_opcode)
              OPC_TOUCH_UP: touch_is_down = 1'b0;
              OPC_HOME:     home_flag = 1'b1;
              OPC_GPS:      parse_state = PARSE_GPS_LEN;
              default:      parse_state = PARSE_PAYLOAD;
            endcase
          end
        end
        PARSE_GPS_LEN: begin
          gps_left = b;
          parse_state = (b == 8'd0) ? PARSE_IDLE : PARSE_GPS_DATA;
        end
        PARSE_GPS_DATA: begin
          r.kind = EV_GPS;
          r.value_a = b;
          gps_left = gps_left - 8'd1;
          if (gps_left == 8'd0) parse_state = PARSE_IDLE;
        end
        default: begin
          payload_word = payload_word | ({24'd0, b} << {payload_count[1:0], 3'b000});
          payload_count = payload_count + 3'd1;
          case (cur_opcode)
            OPC_KEY, OPC_BATTERY: need = 3'd2;
            OPC_TOUCH, OPC_SENSOR: need = 3'd4;
            default: need = 3'd0;
          endcase
          if (payload_count >= need) begin
            {p3, p2, p1, p0} = payload_word;
            case (cur_opcode)
              OPC_KEY: begin
                // Key numbers other than boot and side are ignored.
                if (p0 == KEY_BOOT) update_key(BOOT_SLOT, p1 != 8'd0);
                else if (p0 == KEY_SIDE) update_key(SIDE_SLOT, p1 != 8'd0);
              end
              OPC_TOUCH: begin
                touch_x_last = {p1, p0};
                touch_y_last = {p3, p2};
                touch_is_down = 1'b1;
              end
              OPC_SENSOR: begin
                r.kind = EV_SENSOR;
                power = {p2, p1};
                if (p0 != ABSENT_U8) begin
                  r.value_a = p0;
                  r.present[HR_BIT] = 1'b1;
                end
                if (power != ABSENT_U16) begin
                  r.value_b = power;
                  r.present[POWER_BIT] = 1'b1;
                end
                if (p3 != ABSENT_U8) begin
                  r.value_c = p3;
                  r.present[CADENCE_BIT] = 1'b1;
                end
              end
              OPC_BATTERY: begin
                r.kind = EV_BATTERY;
                r.value_a = p0;
                r.value_b = {15'd0, p1 != 8'd0};
              end
              default: ;
            endcase
            parse_state = PARSE_IDLE;
            payload_count = '0;
            payload_word = '0;
          end
        end
      endcase
    end else if (op == OP_TICK) begin
      now_ms = now_ms + 32'd1;
    end
    // A poll reports the pending home press and then clears it.
    r.home = home_flag;
    if (op == OP_POLL) home_flag = 1'b0;
    r.boot = resolve_key(BOOT_SLOT);
    r.side = resolve_key(SIDE_SLOT);
    r.touch = touch_is_down;
    r.x = touch_x_last;
    r.y = touch_y_last;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by the processes below.
  // ---------------------------------------------------------------------------
  stream_item_t stream_backlog[$];
  status_beat_t predicted_status[$];
  stream_item_t next_item;
  status_beat_t want;
  int items_queued = 0;
  int items_taken = 0;
  int beats_checked = 0;
  int gps_seen = 0;
  int sensor_seen = 0;
  int battery_seen = 0;
  int failures = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Driver: offers the backlog one beat at a time. When a beat is accepted it
  // is run through the predictor right away, so expectations stay in order.
  // A new beat is loaded only when the line is empty or its beat was taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_status.push_back(decode_beat(in_op, in_data_byte));
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (stream_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_item = stream_backlog.pop_front();
          in_valid <= 1'b1;
          in_op <= next_item.op;
          in_data_byte <= next_item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input logic [15:0] exp_val,
                             input logic [15:0] got_val);
    if (exp_val !== got_val) begin
      failures++;
      if (failures <= PRINT_LIMIT)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, exp_val, got_val);
    end
  endtask

  // Monitor: every result beat is matched against the oldest prediction.
  // The receiver stalls at random, and throughout a hold-off.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (predicted_status.size() == 0) begin
          failures++;
          $display("%0t ns: result beat with no prediction waiting", $time);
        end else begin
          want = predicted_status.pop_front();
          beats_checked++;
          case (want.kind)
            EV_GPS:     gps_seen++;
            EV_SENSOR:  sensor_seen++;
            EV_BATTERY: battery_seen++;
            default: ;
          endcase
          check_field("event_kind", 16'(want.kind), 16'(out_event_kind));
          check_field("value_a", 16'(want.value_a), 16'(out_value_a));
          check_field("value_b", want.value_b, out_value_b);
          check_field("value_c", 16'(want.value_c), 16'(out_value_c));
          check_field("present_mask", 16'(want.present), 16'(out_present_mask));
          check_field("boot_down", 16'(want.boot), 16'(out_boot_down));
          check_field("side_down", 16'(want.side), 16'(out_side_down));
          check_field("touch_down", 16'(want.touch), 16'(out_touch_down));
          check_field("touch_x", want.x, out_touch_x);
          check_field("touch_y", want.y, out_touch_y);
          check_field("home_press", 16'(want.home), 16'(out_home_press));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Hold-off counter: a request from the sequence below starts a long stretch
  // with the receiver not ready, so the result register fills and the input
  // side backs up while the driver keeps offering beats.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog: ends the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: watchdog, no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers and the test sequence.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] opcode_byte(input opcode_t code);
    return {OPC_BYTE_FIRST[7:3], code};
  endfunction

  function automatic void push_item(input op_t op, input logic [7:0] data);
    stream_item_t item;
    item.op = op;
    item.data = data;
    stream_backlog.push_back(item);
    items_queued++;
  endfunction

  // Mostly well-formed event frames with random content, plus tick bursts,
  // polls, stray bytes, unused ops and opcodes whose payload never follows.
  task automatic queue_random_traffic(input int n_items);
    int stop_at;
    int pick;
    int len;
    logic [15:0] word;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        push_item(OP_BYTE, opcode_byte(OPC_KEY));
        if ($urandom_range(0, 9) != 0)
          push_item(OP_BYTE, ($urandom_range(0, 1) != 0) ? KEY_BOOT : KEY_SIDE);
        else
          push_item(OP_BYTE, 8'($urandom));
        if ($urandom_range(0, 1) != 0)
          push_item(OP_BYTE, KEY_UP_BYTE);
        else
          push_item(OP_BYTE, 8'($urandom_range(1, 255)));
      end else if (pick < 38) begin
        // Short tick bursts so that deferred key releases come due.
        len = $urandom_range(1, 12);
        repeat (len) push_item(OP_TICK, 8'($urandom));
      end else if (pick < 48) begin
        push_item(OP_BYTE, opcode_byte(OPC_TOUCH));
        repeat (4) push_item(OP_BYTE, 8'($urandom));
      end else if (pick < 53) begin
        push_item(OP_BYTE, opcode_byte(OPC_TOUCH_UP));
      end else if (pick < 58) begin
        push_item(OP_BYTE, opcode_byte(OPC_HOME));
      end else if (pick < 65) begin
        push_item(OP_POLL, 8'($urandom));
      end else if (pick < 75) begin
        // Mostly short GPS frames; now and then a long one.
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 6);
        push_item(OP_BYTE, opcode_byte(OPC_GPS));
        push_item(OP_BYTE, 8'(len));
        repeat (len) push_item(OP_BYTE, 8'($urandom));
      end else if (pick < 85) begin
        word = ($urandom_range(0, 3) == 0) ? ABSENT_U16 : 16'($urandom);
        push_item(OP_BYTE, opcode_byte(OPC_SENSOR));
        push_item(OP_BYTE, ($urandom_range(0, 3) == 0) ? ABSENT_U8 : 8'($urandom));
        push_item(OP_BYTE, word[7:0]);
        push_item(OP_BYTE, word[15:8]);
        push_item(OP_BYTE, ($urandom_range(0, 3) == 0) ? ABSENT_U8 : 8'($urandom));
      end else if (pick < 92) begin
        push_item(OP_BYTE, opcode_byte(OPC_BATTERY));
        push_item(OP_BYTE, 8'($urandom));
        push_item(OP_BYTE, ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom));
      end else if (pick < 97) begin
        push_item(OP_BYTE, 8'($urandom));
      end else if (pick < 99) begin
        push_item(OP_NONE, 8'($urandom));
      end else begin
        // A bare opcode: whatever follows is taken as its payload.
        push_item(OP_BYTE, opcode_byte(opcode_t'($urandom_range(1, 7))));
      end
    end
  endtask

  task automatic wait_until_drained();
    while (items_taken != items_queued || predicted_status.size() != 0)
      @(posedge clk);
  endtask

  // The register is only written with nothing in flight.
  task automatic write_min_hold(input logic [15:0] hold_ms);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_min_hold_ms <= hold_ms;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    hold_ms_copy = hold_ms;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] hold_ms, input int idle_pct,
                           input int stall_pct, input int n_items, input bit hold_off);
    write_min_hold(hold_ms);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    if (hold_off) hold_requests <= hold_requests + 1;
    queue_random_traffic(n_items);
    wait_until_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset hold of 250 ms, with no idling.
    // Home press, then an unused op and a tick report it unchanged around
    // the poll that clears it.
    push_item(OP_BYTE, opcode_byte(OPC_HOME));
    push_item(OP_NONE, 8'hFF);
    push_item(OP_POLL, 8'h00);
    push_item(OP_TICK, 8'hFF);
    // Bytes just outside the opcode range are dropped.
    push_item(OP_BYTE, OPC_BYTE_FIRST - 8'd1);
    push_item(OP_BYTE, OPC_BYTE_LAST + 8'd1);
    // GPS frame of length zero.
    push_item(OP_BYTE, opcode_byte(OPC_GPS));
    push_item(OP_BYTE, 8'd0);
    // Sensor frame with every value absent.
    push_item(OP_BYTE, opcode_byte(OPC_SENSOR));
    repeat (4) push_item(OP_BYTE, ABSENT_U8);
    // Battery at full byte range while charging.
    push_item(OP_BYTE, opcode_byte(OPC_BATTERY));
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BYTE, 8'h01);
    // Touch at the most negative x and the most positive y.
    push_item(OP_BYTE, opcode_byte(OPC_TOUCH));
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'h80);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BYTE, 8'h7F);
    // Boot key pressed and released at once: the release must be deferred.
    push_item(OP_BYTE, opcode_byte(OPC_KEY));
    push_item(OP_BYTE, KEY_BOOT);
    push_item(OP_BYTE, KEY_DOWN_BYTE);
    push_item(OP_BYTE, opcode_byte(OPC_KEY));
    push_item(OP_BYTE, KEY_BOOT);
    push_item(OP_BYTE, KEY_UP_BYTE);
    wait_until_drained();

    // Random phases: hold setting, sender idle %, receiver stall %, beats.
    run_phase(16'd0, 0, 0, 170, 1'b0);
    run_phase(16'd4, 86, 0, 150, 1'b0);
    run_phase(16'hFFFF, 0, 86, 150, 1'b0);
    run_phase(16'($urandom_range(1, 12)), 9, 9, 170, 1'b0);
    run_phase(16'd1, 0, 0, 60, 1'b1);
    run_phase(16'd7, 9, 9, 150, 1'b0);

    // Let any stray result beat show up before the verdict.
    repeat (8) @(posedge clk);
    if (predicted_status.size() != 0) begin
      failures++;
      $display("%0t ns: %0d predicted beats never arrived", $time, predicted_status.size());
    end

    $display("Run covered %0d input beats over six traffic phases, hold settings 0 to 65535.",
             items_taken);
    $display("Checked %0d result beats: %0d gps, %0d sensor, %0d battery; %0d mismatches.",
             beats_checked, gps_seen, sensor_seen, battery_seen, failures);
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
rtl/iesd_pkg.sv
rtl/input_event_stream_decoder.sv
verif/input_event_stream_decoder_tb.sv
